### rtl/nfi_pkg.sv
package nfi_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_POINTS = 16;
   localparam int DEF_FRAC_BITS  = 16;

   // Field widths of the ports.
   localparam int XW  = 32;
   localparam int NPW = 5;
   localparam int PIW = 4;
   localparam int STW = 2;

   // Intermediate values (u, binomial terms, products, coefficients).
   localparam int QW = 48;

   // Multiplier operand magnitude width and half width.
   localparam int MW = 50;
   localparam int HW = MW / 2;
   localparam int PW = 2 * MW;

   // Iterative divider.
   localparam int DIV_W  = 64;
   localparam int DIS_W  = 33;
   localparam int DIV_CW = 7;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [STW-1:0] STATUS_OK   = 2'd0;
   localparam logic [STW-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STW-1:0] STATUS_SAT  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_COPY_END,
      ST_DIFF,
      ST_DRAIN,
      ST_EVAL,
      ST_UDIV,
      ST_MA_GO,
      ST_MA_WAIT,
      ST_BD_GO,
      ST_BDIV,
      ST_MB_GO,
      ST_MB_WAIT,
      ST_FINISH
   } state_type;

endpackage

### rtl/newton_forward_interpolator.sv
// Channel   Ports                                   Direction  Handshake
// request   req_operation, req_point_index,         in         start high, busy low
//           req_x_value, req_y_value
// response  rsp_interpolated, rsp_status            out        rsp_valid, one cycle
// config    csr_wdata                               in         csr_we
//
// A load item writes the point memory and busy stays low.
// An evaluate item first rebuilds the difference table if it is stale:
// it copies the ordinates into the coefficient memory and then runs the
// difference passes, one read a cycle. Evaluation then works term by term with
// the one-bit-per-cycle divider and the four-pass 25x25 multiplier.
// Reset is synchronous; the point memories are not cleared.
// The result is shown for one cycle and cannot be stalled.
module newton_forward_interpolator #(
   parameter int MAX_POINTS = nfi_pkg::DEF_MAX_POINTS,
   parameter int FRAC_BITS  = nfi_pkg::DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_operation,
   input  logic [nfi_pkg::PIW-1:0]    req_point_index,
   input  logic signed [nfi_pkg::XW-1:0] req_x_value,
   input  logic signed [nfi_pkg::XW-1:0] req_y_value,
   output logic                       rsp_valid,
   output logic signed [nfi_pkg::XW-1:0] rsp_interpolated,
   output logic [nfi_pkg::STW-1:0]    rsp_status,
   input  logic                       csr_we,
   input  logic [nfi_pkg::NPW-1:0]    csr_wdata
);
   import nfi_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int SW = QW + 7;
   localparam logic [PW-1:0] LIM_POS = PW'({1'b0, {(QW-1){1'b1}}});
   localparam logic [PW-1:0] LIM_NEG = LIM_POS + PW'(1);

   function automatic logic over_lim(input logic neg, input logic [PW-1:0] m);
      return m > (neg ? LIM_NEG : LIM_POS);
   endfunction

   function automatic logic signed [QW-1:0] sign_sat(input logic neg,
                                                    input logic [PW-1:0] m);
      logic [PW-1:0] mag;
      mag = over_lim(neg, m) ? (neg ? LIM_NEG : LIM_POS) : m;
      return neg ? -QW'(mag) : QW'(mag);
   endfunction

   state_type state_ff, state_in;

   logic [NPW-1:0] num_points_ff;
   logic           stale_ff;
   logic [NW-1:0]  n_used;
   logic [NW-1:0]  n_last;
   logic           accept;

   logic signed [XW-1:0] x_ff, x0_ff, x1_ff;
   logic signed [QW-1:0] u_ff, binom_ff, prev_ff;
   logic signed [SW-1:0] sum_ff;
   logic                 sat_ff, zsp_ff, uneg_ff, bneg_ff;
   logic [NW-1:0]        term_ff, pass_ff, rd_ff, arr_idx_ff;
   logic                 arr_vld_ff, arr_copy_ff, arr_first_ff;

   logic                 rsp_valid_ff;
   logic signed [XW-1:0] rsp_val_ff;
   logic [STW-1:0]       rsp_st_ff;

   // Memories.
   logic            ord_we;
   logic [AW-1:0]   ord_waddr, ord_raddr;
   logic [XW-1:0]   ord_rdata;
   logic            coef_we;
   logic [AW-1:0]   coef_waddr, coef_raddr;
   logic [QW-1:0]   coef_wdata, coef_rdata;

   // Divider.
   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_dividend, div_quo;
   logic [DIS_W-1:0]  div_divisor;
   logic [DIV_CW-1:0] div_steps;

   // Multiplier.
   logic              mul_start, mul_run_ff, mul_done_ff, mneg_ff;
   logic [2:0]        mul_cnt_ff;
   logic [1:0]        mul_k;
   logic [MW-1:0]     ma_ff, mb_ff, pp_ff;
   logic [PW-1:0]     acc_ff, mul_m;
   logic signed [MW-1:0] mul_a, mul_b;
   logic [HW-1:0]     half_a, half_b;

   logic signed [DIS_W-1:0] den, num;
   logic [DIS_W-1:0]        mden, mnum;
   logic signed [QW-1:0]    prod_s;
   logic signed [SW-1:0]    sum_next;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign n_used = (num_points_ff < NPW'(2)) ? NW'(2) :
                   (32'(num_points_ff) > MAX_POINTS) ? NW'(MAX_POINTS) :
                   NW'(num_points_ff);
   assign n_last = n_used - NW'(1);

   assign den  = DIS_W'(x1_ff) - DIS_W'(x0_ff);
   assign num  = DIS_W'(x_ff) - DIS_W'(x0_ff);
   assign mden = den[DIS_W-1] ? DIS_W'(-den) : DIS_W'(den);
   assign mnum = num[DIS_W-1] ? DIS_W'(-num) : DIS_W'(num);

   assign mul_m    = acc_ff >> FRAC_BITS;
   assign prod_s   = sign_sat(mneg_ff, mul_m);
   assign sum_next = sum_ff + SW'(prod_s);

   nfi_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_ord_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (req_y_value),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   nfi_ram #(.WIDTH(QW), .DEPTH(MAX_POINTS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   nfi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation == OP_EVAL) begin
               state_in = stale_ff ? ST_COPY : ST_EVAL;
            end
         end
         ST_COPY:     if (rd_ff == n_last) state_in = ST_COPY_END;
         ST_COPY_END: state_in = ST_DIFF;
         ST_DIFF:     if (rd_ff == pass_ff - NW'(1)) state_in = ST_DRAIN;
         ST_DRAIN:    state_in = (pass_ff == n_last) ? ST_EVAL : ST_DIFF;
         ST_EVAL:     state_in = (den == '0) ? ST_FINISH : ST_UDIV;
         ST_UDIV:     if (div_done) state_in = ST_MA_GO;
         ST_MA_GO:    state_in = ST_MA_WAIT;
         ST_MA_WAIT:  if (mul_done_ff) state_in = ST_BD_GO;
         ST_BD_GO:    state_in = ST_BDIV;
         ST_BDIV:     if (div_done) state_in = ST_MB_GO;
         ST_MB_GO:    state_in = ST_MB_WAIT;
         ST_MB_WAIT: begin
            if (mul_done_ff) begin
               state_in = (term_ff == n_last) ? ST_FINISH : ST_MA_GO;
            end
         end
         ST_FINISH:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      ord_we       = accept && req_operation == OP_LOAD &&
                     32'(req_point_index) < MAX_POINTS;
      ord_waddr    = AW'(req_point_index);
      ord_raddr    = AW'(rd_ff);
      coef_raddr   = (state_ff == ST_DIFF) ? AW'(rd_ff) : AW'(term_ff);
      coef_we      = arr_vld_ff && (arr_copy_ff || !arr_first_ff);
      coef_waddr   = arr_copy_ff ? AW'(arr_idx_ff) : AW'(arr_idx_ff + NW'(1));
      coef_wdata   = arr_copy_ff ? QW'(signed'(ord_rdata)) : prev_ff - coef_rdata;
      div_start    = 1'b0;
      div_dividend = DIV_W'(mnum) << FRAC_BITS;
      div_divisor  = mden;
      div_steps    = DIV_CW'(DIS_W + FRAC_BITS);
      mul_start    = 1'b0;
      mul_a        = MW'(binom_ff);
      mul_b        = MW'(u_ff) - (MW'(term_ff - NW'(1)) << FRAC_BITS);
      unique case (state_ff)
         ST_EVAL:  div_start = (den != '0);
         ST_MA_GO: mul_start = 1'b1;
         ST_BD_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(binom_ff[QW-1] ? QW'(-binom_ff) : QW'(binom_ff));
            div_divisor  = DIS_W'(term_ff);
            div_steps    = DIV_CW'(QW);
         end
         ST_MB_GO: begin
            mul_start = 1'b1;
            mul_b     = MW'(signed'(coef_rdata));
         end
         default: ;
      endcase
   end

   // Multiplier: four 25x25 partial products, each registered, then added.
   assign mul_k  = 2'(mul_cnt_ff - 3'd1);
   assign half_a = mul_cnt_ff[1] ? ma_ff[MW-1:HW] : ma_ff[HW-1:0];
   assign half_b = mul_cnt_ff[0] ? mb_ff[MW-1:HW] : mb_ff[HW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_run_ff  <= 1'b0;
         mul_done_ff <= 1'b0;
         mul_cnt_ff  <= '0;
      end else begin
         mul_done_ff <= mul_run_ff && mul_cnt_ff == 3'd4;
         if (mul_start) begin
            mul_run_ff <= 1'b1;
            mul_cnt_ff <= '0;
         end else if (mul_run_ff) begin
            mul_cnt_ff <= mul_cnt_ff + 3'd1;
            if (mul_cnt_ff == 3'd4) begin
               mul_run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_start) begin
         ma_ff   <= mul_a[MW-1] ? MW'(-mul_a) : MW'(mul_a);
         mb_ff   <= mul_b[MW-1] ? MW'(-mul_b) : MW'(mul_b);
         mneg_ff <= mul_a[MW-1] ^ mul_b[MW-1];
         acc_ff  <= '0;
      end else if (mul_run_ff) begin
         pp_ff <= MW'(half_a * half_b);
         if (mul_cnt_ff != 3'd0) begin
            acc_ff <= acc_ff + ((PW'(pp_ff) << (mul_k[1] ? HW : 0)) << (mul_k[0] ? HW : 0));
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_points_ff <= NPW'(2);
         stale_ff      <= 1'b1;
         arr_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         x0_ff         <= '0;
         x1_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_FINISH);
         arr_vld_ff   <= (state_ff == ST_COPY) || (state_ff == ST_DIFF);
         if (csr_we) begin
            num_points_ff <= csr_wdata;
            stale_ff      <= 1'b1;
         end
         if (ord_we) begin
            stale_ff <= 1'b1;
            if (req_point_index == PIW'(0)) x0_ff <= req_x_value;
            if (req_point_index == PIW'(1)) x1_ff <= req_x_value;
         end
         if (state_ff == ST_DRAIN && pass_ff == n_last) begin
            stale_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      arr_copy_ff  <= (state_ff == ST_COPY);
      arr_first_ff <= (rd_ff == n_last);
      arr_idx_ff   <= rd_ff;
      if (arr_vld_ff && !arr_copy_ff) begin
         prev_ff <= coef_rdata;
      end
      unique case (state_ff)
         ST_IDLE: begin
            x_ff  <= req_x_value;
            rd_ff <= '0;
         end
         ST_COPY: begin
            if (rd_ff != n_last) rd_ff <= rd_ff + NW'(1);
         end
         ST_COPY_END: begin
            pass_ff <= NW'(1);
            rd_ff   <= n_last;
         end
         ST_DIFF: begin
            if (rd_ff != pass_ff - NW'(1)) rd_ff <= rd_ff - NW'(1);
         end
         ST_DRAIN: begin
            pass_ff <= pass_ff + NW'(1);
            rd_ff   <= n_last;
         end
         ST_EVAL: begin
            term_ff <= '0;
            sat_ff  <= 1'b0;
            zsp_ff  <= (den == '0);
            uneg_ff <= num[DIS_W-1] ^ den[DIS_W-1];
         end
         ST_UDIV: begin
            if (div_done) begin
               u_ff     <= sign_sat(uneg_ff, PW'(div_quo));
               sat_ff   <= sat_ff | over_lim(uneg_ff, PW'(div_quo));
               sum_ff   <= SW'(signed'(coef_rdata));
               binom_ff <= QW'(1) << FRAC_BITS;
               term_ff  <= NW'(1);
            end
         end
         ST_MA_WAIT: begin
            if (mul_done_ff) begin
               binom_ff <= prod_s;
               sat_ff   <= sat_ff | over_lim(mneg_ff, mul_m);
            end
         end
         ST_BD_GO: bneg_ff <= binom_ff[QW-1];
         ST_BDIV: begin
            if (div_done) begin
               binom_ff <= bneg_ff ? -QW'(div_quo) : QW'(div_quo);
            end
         end
         ST_MB_WAIT: begin
            if (mul_done_ff) begin
               sum_ff <= sum_next;
               sat_ff <= sat_ff | over_lim(mneg_ff, mul_m);
               if (term_ff != n_last) term_ff <= term_ff + NW'(1);
            end
         end
         ST_FINISH: begin
            if (zsp_ff) begin
               rsp_val_ff <= '0;
               rsp_st_ff  <= STATUS_ZERO;
            end else if (sum_ff > SW'(32'sh7FFF_FFFF)) begin
               rsp_val_ff <= 32'sh7FFF_FFFF;
               rsp_st_ff  <= STATUS_SAT;
            end else if (sum_ff < -SW'(64'sh8000_0000)) begin
               rsp_val_ff <= 32'sh8000_0000;
               rsp_st_ff  <= STATUS_SAT;
            end else begin
               rsp_val_ff <= XW'(sum_ff);
               rsp_st_ff  <= sat_ff ? STATUS_SAT : STATUS_OK;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interpolated = rsp_val_ff;
   assign rsp_status       = rsp_st_ff;

endmodule

### rtl/nfi_ram.sv
module nfi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nfi_div.sv
module nfi_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [nfi_pkg::DIV_W-1:0]   dividend,
   input  logic [nfi_pkg::DIS_W-1:0]   divisor,
   input  logic [nfi_pkg::DIV_CW-1:0]  steps,
   output logic                        done,
   output logic [nfi_pkg::DIV_W-1:0]   quotient
);
   import nfi_pkg::*;

   logic              run_ff;
   logic              done_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [DIV_W-1:0]  dvd_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [DIS_W-1:0]  rem_ff;
   logic [DIS_W-1:0]  dsr_ff;
   logic [DIS_W:0]    trial;
   logic [DIS_W:0]    diff;
   logic              fits;

   // One quotient bit per cycle, restoring form.
   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == DIV_CW'(1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= steps;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - DIV_CW'(1);
            if (cnt_ff == DIV_CW'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // Align the first quotient bit with the top of the shift register.
         dvd_ff <= dividend << (DIV_CW'(DIV_W) - steps);
         rem_ff <= '0;
         quo_ff <= '0;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= fits ? diff[DIS_W-1:0] : trial[DIS_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
